// ----- rtl/dcsq_pkg.sv -----
package dcsq_pkg;

    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_QUERY  = 2'd1,
        OP_FREE   = 2'd2,
        OP_POP    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_REJECT = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_EXEC  = 2'd1,
        BK_READ  = 2'd2,
        BK_REPLY = 2'd3
    } bk_state_t;

    typedef struct packed {
        logic [1:0]  op;
        logic        kind;
        logic [31:0] buffer_address;
        logic [27:0] sector_address;
        logic [7:0]  slot;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  slot_id;
        logic        is_ready;
        logic        popped_kind;
        logic [31:0] popped_buffer_address;
        logic [27:0] popped_sector_address;
    } result_t;

    localparam logic [8:0] END_MARK = 9'h100;

endpackage

// ----- rtl/dcsq_front.sv -----
module dcsq_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  dcsq_pkg::cmd_t  command,
    input  logic            take,
    output logic            busy,
    output logic            avail,
    output dcsq_pkg::cmd_t  item
);

    // one-entry queue between front and back
    logic           full_reg;
    logic           full_next;
    dcsq_pkg::cmd_t item_reg;

    assign busy  = full_reg;
    assign avail = full_reg;
    assign item  = item_reg;

    always_comb
    begin
        full_next = full_reg;
        if (take)
        begin
            full_next = 1'b0;
        end
        if (start && !full_reg)
        begin
            full_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !full_reg)
        begin
            item_reg <= command;
        end
    end

endmodule

// ----- rtl/dcsq_back.sv -----
module dcsq_back
#(
    parameter int NUM_SLOTS = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              avail,
    input  dcsq_pkg::cmd_t    item,
    output logic              take,
    output logic              done,
    output dcsq_pkg::result_t result
);

    localparam int POOL = (NUM_SLOTS < 256) ? NUM_SLOTS : 256;

    dcsq_pkg::bk_state_t state_reg;
    dcsq_pkg::bk_state_t state_next;

    logic [POOL-1:0] used_reg;
    logic [POOL-1:0] ready_reg;
    logic [POOL-1:0] queued_reg;
    logic [8:0]      head_reg;
    logic [7:0]      tail_reg;

    logic [60:0]     entry_mem [POOL];
    logic [8:0]      next_mem  [POOL];
    logic [60:0]     entry_rd_reg;
    logic [8:0]      next_rd_reg;

    dcsq_pkg::cmd_t    cmd_reg;
    dcsq_pkg::result_t result_reg;
    dcsq_pkg::result_t result_next;

    logic       found;
    logic [7:0] alloc_slot;
    logic       slot_in_pool;
    logic [7:0] head_slot;

    assign head_slot    = head_reg[7:0];
    assign slot_in_pool = (32'(cmd_reg.slot) < POOL);

    // lowest unused slot; scan over the pool bitmap
    always_comb
    begin
        found      = 1'b0;
        alloc_slot = '0;
        for (int s = POOL - 1; s >= 1; s--)
        begin
            if (!used_reg[s])
            begin
                found      = 1'b1;
                alloc_slot = 8'(s);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dcsq_pkg::BK_IDLE:
            begin
                if (avail)
                begin
                    state_next = dcsq_pkg::BK_EXEC;
                end
            end
            dcsq_pkg::BK_EXEC:
            begin
                if (cmd_reg.op == dcsq_pkg::OP_POP && head_reg != dcsq_pkg::END_MARK)
                begin
                    state_next = dcsq_pkg::BK_READ;
                end
                else
                begin
                    state_next = dcsq_pkg::BK_REPLY;
                end
            end
            dcsq_pkg::BK_READ:  state_next = dcsq_pkg::BK_REPLY;
            dcsq_pkg::BK_REPLY: state_next = dcsq_pkg::BK_IDLE;
            default:            state_next = dcsq_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        take = 1'b0;
        done = 1'b0;
        unique case (state_reg)
            dcsq_pkg::BK_IDLE:  take = avail;
            dcsq_pkg::BK_REPLY: done = 1'b1;
            default:
            begin
                take = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= dcsq_pkg::BK_IDLE;
            used_reg   <= POOL'(1);
            ready_reg  <= '0;
            queued_reg <= '0;
            head_reg   <= dcsq_pkg::END_MARK;
            tail_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == dcsq_pkg::BK_EXEC)
            begin
                unique case (dcsq_pkg::op_t'(cmd_reg.op))
                    dcsq_pkg::OP_CREATE:
                    begin
                        if (found)
                        begin
                            used_reg[alloc_slot]   <= 1'b1;
                            ready_reg[alloc_slot]  <= 1'b0;
                            queued_reg[alloc_slot] <= 1'b1;
                            if (head_reg == dcsq_pkg::END_MARK)
                            begin
                                head_reg <= {1'b0, alloc_slot};
                            end
                            tail_reg <= alloc_slot;
                        end
                    end
                    dcsq_pkg::OP_FREE:
                    begin
                        if (cmd_reg.slot != 8'd0 && slot_in_pool
                            && !queued_reg[cmd_reg.slot])
                        begin
                            used_reg[cmd_reg.slot] <= 1'b0;
                        end
                    end
                    dcsq_pkg::OP_POP:
                    begin
                        if (head_reg != dcsq_pkg::END_MARK)
                        begin
                            ready_reg[head_slot]  <= 1'b1;
                            queued_reg[head_slot] <= 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == dcsq_pkg::BK_READ)
            begin
                head_reg <= next_rd_reg;
                if (next_rd_reg == dcsq_pkg::END_MARK)
                begin
                    tail_reg <= '0;
                end
            end
        end
    end

    // entry stores: one write port, registered read at the head
    always_ff @(posedge clk)
    begin
        if (state_reg == dcsq_pkg::BK_EXEC && cmd_reg.op == dcsq_pkg::OP_CREATE && found)
        begin
            entry_mem[alloc_slot] <= {cmd_reg.kind, cmd_reg.buffer_address,
                                      cmd_reg.sector_address};
        end
        entry_rd_reg <= entry_mem[head_slot];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == dcsq_pkg::BK_EXEC && cmd_reg.op == dcsq_pkg::OP_CREATE && found)
        begin
            next_mem[alloc_slot] <= dcsq_pkg::END_MARK;
            if (head_reg != dcsq_pkg::END_MARK)
            begin
                next_mem[tail_reg] <= {1'b0, alloc_slot};
            end
        end
        next_rd_reg <= next_mem[head_slot];
    end

    always_comb
    begin
        result_next = result_reg;
        if (state_reg == dcsq_pkg::BK_EXEC)
        begin
            result_next = '0;
            unique case (dcsq_pkg::op_t'(cmd_reg.op))
                dcsq_pkg::OP_CREATE:
                begin
                    if (found)
                    begin
                        result_next.slot_id = alloc_slot;
                    end
                    else
                    begin
                        result_next.status = dcsq_pkg::ST_FULL;
                    end
                end
                dcsq_pkg::OP_QUERY:
                begin
                    result_next.is_ready = slot_in_pool && ready_reg[cmd_reg.slot];
                end
                dcsq_pkg::OP_FREE:
                begin
                    if (cmd_reg.slot == 8'd0 || !slot_in_pool || queued_reg[cmd_reg.slot])
                    begin
                        result_next.status = dcsq_pkg::ST_REJECT;
                    end
                end
                dcsq_pkg::OP_POP:
                begin
                    if (head_reg == dcsq_pkg::END_MARK)
                    begin
                        result_next.status = dcsq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        result_next.slot_id = head_slot;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (state_reg == dcsq_pkg::BK_READ)
        begin
            result_next.popped_kind           = entry_rd_reg[60];
            result_next.popped_buffer_address = entry_rd_reg[59:28];
            result_next.popped_sector_address = entry_rd_reg[27:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= item;
        end
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

// ----- rtl/disk_command_slot_queue_unit.sv -----
// A command waits in the front's one-entry queue, is taken in BK_IDLE,
// runs in BK_EXEC and is strobed in BK_REPLY; a pop that returns a command
// also passes BK_READ. The back-end sequencer takes a new command only in
// BK_IDLE; the front holds one command while the back works.
// Reset: asynchronous, active low; slot 0 used, queue empty, no results pending.
// The receiver cannot stall: each result is strobed for one cycle.
module disk_command_slot_queue_unit
#(
    parameter int NUM_SLOTS = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  dcsq_pkg::cmd_t    command,
    output logic              busy,
    output logic              strobe,
    output dcsq_pkg::result_t result
);

    logic           take;
    logic           avail;
    dcsq_pkg::cmd_t item;

    dcsq_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .take    (take),
        .busy    (busy),
        .avail   (avail),
        .item    (item)
    );

    dcsq_back #(.NUM_SLOTS(NUM_SLOTS)) u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .avail  (avail),
        .item   (item),
        .take   (take),
        .done   (strobe),
        .result (result)
    );

    a_take_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> avail)
        else $error("back took with empty queue");

    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> !strobe)
        else $error("result strobe held");

    a_full_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.status == dcsq_pkg::ST_FULL) |-> result.slot_id == 8'd0)
        else $error("full status with slot");

endmodule
